>>> rtl/iterated_box_blur_rgba_assert.svh
// Assertion macros for the checks in the top-level blur module.
`ifndef ITERATED_BOX_BLUR_RGBA_ASSERT_SVH
`define ITERATED_BOX_BLUR_RGBA_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IBB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ibb_pkg.sv
// ----------------------------------------------------------------------------
// ibb_pkg
// Types and constants of the iterated box blur: widths, codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ibb_pkg;

  localparam int SIZE_W = 9;
  localparam int RAD_W  = 8;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 17;
  localparam int PROD_W = 18;
  localparam int LANES  = 4;
  localparam int PIX_W  = LANES * BYTE_W;
  localparam int CIDX_W = 2;

  localparam logic [RAD_W-1:0] RADIUS_MAX = 8'd250;

  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_FETCH = 15'h0002,
    S_LINE  = 15'h0004,
    S_IADDR = 15'h0008,
    S_IRD   = 15'h0010,
    S_IACC  = 15'h0020,
    S_DIV   = 15'h0040,
    S_DWAIT = 15'h0080,
    S_WR    = 15'h0100,
    S_OADDR = 15'h0200,
    S_ORD   = 15'h0400,
    S_OACC  = 15'h0800,
    S_PADDR = 15'h1000,
    S_PRD   = 15'h2000,
    S_PACC  = 15'h4000
  } state_t;

  typedef struct packed {
    logic clr_sums;
    logic acc_add;
    logic acc_sub;
    logic div_start;
    logic mul_go;
    logic rd_go;
    logic wr_go;
    logic src_pass;
    logic ld_wr;
    logic fetch_rd;
    logic out_load;
    logic out_blank;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/ibb_in_if.sv
// ----------------------------------------------------------------------------
// ibb_in_if
// Input channel: one load or fetch item with its four pixel byte lanes.
// ----------------------------------------------------------------------------
interface ibb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] lane0;
  logic [7:0] lane1;
  logic [7:0] lane2;
  logic [7:0] lane3;

  modport source (output valid, mode, lane0, lane1, lane2, lane3, input ready);
  modport sink (input valid, mode, lane0, lane1, lane2, lane3, output ready);
endinterface

>>> rtl/ibb_out_if.sv
// ----------------------------------------------------------------------------
// ibb_out_if
// Result channel: one blurred pixel with its readout flags.
// ----------------------------------------------------------------------------
interface ibb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_lane0;
  logic [7:0] out_lane1;
  logic [7:0] out_lane2;
  logic [7:0] out_lane3;
  logic       last_pixel;
  logic       no_frame;

  modport source (output valid, out_lane0, out_lane1, out_lane2, out_lane3,
                  last_pixel, no_frame, input ready);
  modport sink (input valid, out_lane0, out_lane1, out_lane2, out_lane3,
                last_pixel, no_frame, output ready);
endinterface

>>> rtl/iterated_box_blur_rgba.sv
// ----------------------------------------------------------------------------
// iterated_box_blur_rgba
// Loads a frame of four-byte pixels, blurs it with repeated horizontal and
// vertical box filters, then streams the blurred pixels out on fetch.
//
//   port      dir  meaning
//   in_item   in   mode 0 loads a pixel, mode 1 fetches the next result
//   out_item  out  blurred pixel, last_pixel and no_frame flags
//   cfg_*     in   frame_width, frame_height, blur_radius writes
//
// A load is stored when accepted; a fetch also waits out any output stall.
// The load that completes a frame starts the blur: ROUNDS times two passes,
// each priming the window sums of a line and then, per pixel, dividing on
// the shared divider and writing the result (one store port per memory).
// Reset is synchronous; the stores need no clearing pass.
// in_item.ready is low while the blur runs or a fetch waits on out_item.
// ----------------------------------------------------------------------------
`include "iterated_box_blur_rgba_assert.svh"

module iterated_box_blur_rgba #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ROUNDS     = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ibb_in_if.sink                      in_item,
  ibb_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [ibb_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ibb_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ibb_pkg::cmd_t              cmd;
  ibb_pkg::stat_t             stat;
  logic [AW-1:0]              pos_addr;
  logic [ibb_pkg::SIZE_W-1:0] mul_major, mul_minor, mul_w, ks;
  logic [ibb_pkg::PIX_W-1:0]  pix_in;

  assign pix_in = {in_item.lane3, in_item.lane2, in_item.lane1, in_item.lane0};

  ibb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ROUNDS     (ROUNDS),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd),
    .pos_addr  (pos_addr),
    .mul_major (mul_major),
    .mul_minor (mul_minor),
    .mul_w     (mul_w),
    .ks        (ks)
  );

  ibb_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .pos_addr  (pos_addr),
    .mul_major (mul_major),
    .mul_minor (mul_minor),
    .mul_w     (mul_w),
    .ks        (ks),
    .pix_in    (pix_in),
    .out_item  (out_item)
  );

  `IBB_ASSERT_IMPLY(a_idle_div, clk, rst_n, in_item.ready, !stat.div_busy, "ready while dividing")
  `IBB_ASSERT_IMPLY(a_wr_port, clk, rst_n, cmd.wr_go, !cmd.ld_wr && !cmd.fetch_rd, "store port clash")
  `IBB_ASSERT_NEXT(a_out_load, clk, rst_n, cmd.out_load, out_item.valid, "result not shown")
  `IBB_ASSERT_IMPLY(a_no_frame, clk, rst_n, out_item.valid && out_item.no_frame, out_item.out_lane0 == 8'd0 && out_item.out_lane3 == 8'd0 && !out_item.last_pixel, "no_frame payload")

endmodule

>>> rtl/ibb_ctrl.sv
// ----------------------------------------------------------------------------
// ibb_ctrl
// Controller: configuration registers, load/readout positions and the
// sequencer that walks rounds, passes, lines and pixels of the blur.
// ----------------------------------------------------------------------------
module ibb_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ROUNDS     = 3,
  parameter int AW         = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ibb_in_if.sink                       in_item,
  input  logic                         cfg_we,
  input  logic [ibb_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ibb_pkg::SIZE_W-1:0]   cfg_data,
  input  ibb_pkg::stat_t               stat,
  output ibb_pkg::cmd_t                cmd,
  output logic [AW-1:0]                pos_addr,
  output logic [ibb_pkg::SIZE_W-1:0]   mul_major,
  output logic [ibb_pkg::SIZE_W-1:0]   mul_minor,
  output logic [ibb_pkg::SIZE_W-1:0]   mul_w,
  output logic [ibb_pkg::SIZE_W-1:0]   ks
);

  localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int SW = ibb_pkg::SIZE_W;

  ibb_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]             frame_w_r, frame_w_nxt;
  logic [SW-1:0]             frame_h_r, frame_h_nxt;
  logic [ibb_pkg::RAD_W-1:0] radius_r, radius_nxt;
  logic [AW-1:0]             load_pos_r, load_pos_nxt;
  logic [AW-1:0]             read_pos_r, read_pos_nxt;
  logic                      ready_r, ready_nxt;
  logic                      last_r, last_nxt;
  logic                      blank_r, blank_nxt;
  logic                      vert_r, vert_nxt;
  logic [RW-1:0]             round_r, round_nxt;
  logic [SW-1:0]             line_r, line_nxt;
  logic [SW-1:0]             j_r, j_nxt;
  logic [SW-1:0]             x_r, x_nxt;

  logic [ibb_pkg::PROD_W-1:0] total;
  logic                       accept;
  logic                       load_done;
  logic                       fetch_last;
  logic [SW-1:0]              len;
  logic [SW-1:0]              nlines;
  logic [SW-1:0]              rad9;
  logic [SW-1:0]              jr;
  logic [SW-1:0]              cx_init;
  logic [SW-1:0]              ox;
  logic [SW:0]                ixs;
  logic [SW-1:0]              ix;
  logic [SW-1:0]              coord;
  logic [ibb_pkg::RAD_W-1:0]  rad_in;

  assign total      = ibb_pkg::PROD_W'(frame_w_r) * ibb_pkg::PROD_W'(frame_h_r);
  assign accept     = in_item.valid && in_item.ready;
  assign load_done  = (32'(load_pos_r) + 32'd1) >= 32'(total);
  assign fetch_last = (32'(read_pos_r) + 32'd1) >= 32'(total);

  assign len    = vert_r ? frame_h_r : frame_w_r;
  assign nlines = vert_r ? frame_w_r : frame_h_r;
  assign rad9   = SW'(radius_r);

  // Clamped window coordinates: edges repeat the nearest pixel.
  assign jr      = j_r - rad9;
  assign cx_init = (j_r < rad9) ? '0 : ((jr >= len) ? len - 1'b1 : jr);
  assign ox      = (x_r < rad9) ? '0 : x_r - rad9;
  assign ixs     = (SW+1)'(x_r) + (SW+1)'(radius_r) + (SW+1)'(1);
  assign ix      = (ixs >= (SW+1)'(len)) ? len - 1'b1 : ixs[SW-1:0];

  always_comb begin
    case (state_r)
      ibb_pkg::S_IADDR: coord = cx_init;
      ibb_pkg::S_OADDR: coord = ox;
      ibb_pkg::S_PADDR: coord = ix;
      default: coord = x_r;
    endcase
  end

  assign mul_major = vert_r ? coord : line_r;
  assign mul_minor = vert_r ? line_r : coord;
  assign mul_w     = frame_w_r;
  assign ks        = {radius_r, 1'b1};
  assign pos_addr  = (in_item.mode == ibb_pkg::MODE_FETCH) ? read_pos_r : load_pos_r;
  assign in_item.ready = (state_r == ibb_pkg::S_IDLE);

  assign rad_in = cfg_data[ibb_pkg::RAD_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    frame_w_nxt  = frame_w_r;
    frame_h_nxt  = frame_h_r;
    radius_nxt   = radius_r;
    load_pos_nxt = load_pos_r;
    read_pos_nxt = read_pos_r;
    ready_nxt    = ready_r;
    last_nxt     = last_r;
    blank_nxt    = blank_r;
    vert_nxt     = vert_r;
    round_nxt    = round_r;
    line_nxt     = line_r;
    j_nxt        = j_r;
    x_nxt        = x_r;
    cmd          = '0;
    cmd.src_pass  = vert_r;
    cmd.out_blank = blank_r;
    cmd.out_last  = last_r;

    if (cfg_we) begin
      case (cfg_index)
        ibb_pkg::CFG_FRAME_WIDTH: begin
          if (cfg_data == '0) frame_w_nxt = SW'(1);
          else if (32'(cfg_data) > MAX_WIDTH) frame_w_nxt = SW'(MAX_WIDTH);
          else frame_w_nxt = cfg_data;
        end
        ibb_pkg::CFG_FRAME_HEIGHT: begin
          if (cfg_data == '0) frame_h_nxt = SW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT) frame_h_nxt = SW'(MAX_HEIGHT);
          else frame_h_nxt = cfg_data;
        end
        ibb_pkg::CFG_BLUR_RADIUS: begin
          if (rad_in == '0) radius_nxt = ibb_pkg::RAD_W'(1);
          else if (rad_in > ibb_pkg::RADIUS_MAX) radius_nxt = ibb_pkg::RADIUS_MAX;
          else radius_nxt = rad_in;
        end
        default: ;
      endcase
    end

    case (state_r)
      ibb_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item.mode == ibb_pkg::MODE_LOAD) begin
            cmd.ld_wr = 1'b1;
            ready_nxt = 1'b0;
            if (load_done) begin
              load_pos_nxt = '0;
              read_pos_nxt = '0;
              vert_nxt     = 1'b0;
              round_nxt    = '0;
              line_nxt     = '0;
              state_nxt    = ibb_pkg::S_LINE;
            end else begin
              load_pos_nxt = load_pos_r + AW'(1);
            end
          end else begin
            if (ready_r) begin
              cmd.fetch_rd = 1'b1;
              blank_nxt    = 1'b0;
              last_nxt     = fetch_last;
              if (fetch_last) begin
                ready_nxt    = 1'b0;
                read_pos_nxt = '0;
              end else begin
                read_pos_nxt = read_pos_r + AW'(1);
              end
            end else begin
              blank_nxt = 1'b1;
              last_nxt  = 1'b0;
            end
            state_nxt = ibb_pkg::S_FETCH;
          end
        end
      end
      ibb_pkg::S_FETCH: begin
        // hold the result until the output register frees up
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ibb_pkg::S_IDLE;
        end
      end
      ibb_pkg::S_LINE: begin
        cmd.clr_sums = 1'b1;
        j_nxt        = '0;
        state_nxt    = ibb_pkg::S_IADDR;
      end
      ibb_pkg::S_IADDR: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ibb_pkg::S_IRD;
      end
      ibb_pkg::S_IRD: begin
        cmd.rd_go = 1'b1;
        state_nxt = ibb_pkg::S_IACC;
      end
      ibb_pkg::S_IACC: begin
        cmd.acc_add = 1'b1;
        if (j_r == {radius_r, 1'b0}) begin
          x_nxt     = '0;
          state_nxt = ibb_pkg::S_DIV;
        end else begin
          j_nxt     = j_r + SW'(1);
          state_nxt = ibb_pkg::S_IADDR;
        end
      end
      ibb_pkg::S_DIV: begin
        cmd.div_start = 1'b1;
        cmd.mul_go    = 1'b1;
        state_nxt     = ibb_pkg::S_DWAIT;
      end
      ibb_pkg::S_DWAIT: begin
        if (!stat.div_busy) state_nxt = ibb_pkg::S_WR;
      end
      ibb_pkg::S_WR: begin
        cmd.wr_go = 1'b1;
        if (x_r == len - 1'b1) begin
          if (line_r == nlines - 1'b1) begin
            line_nxt = '0;
            if (!vert_r) begin
              vert_nxt  = 1'b1;
              state_nxt = ibb_pkg::S_LINE;
            end else begin
              vert_nxt = 1'b0;
              if (round_r == RW'(ROUNDS - 1)) begin
                round_nxt = '0;
                ready_nxt = 1'b1;
                state_nxt = ibb_pkg::S_IDLE;
              end else begin
                round_nxt = round_r + RW'(1);
                state_nxt = ibb_pkg::S_LINE;
              end
            end
          end else begin
            line_nxt  = line_r + SW'(1);
            state_nxt = ibb_pkg::S_LINE;
          end
        end else begin
          state_nxt = ibb_pkg::S_OADDR;
        end
      end
      ibb_pkg::S_OADDR: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ibb_pkg::S_ORD;
      end
      ibb_pkg::S_ORD: begin
        cmd.rd_go = 1'b1;
        state_nxt = ibb_pkg::S_OACC;
      end
      ibb_pkg::S_OACC: begin
        // drop the pixel leaving the window
        cmd.acc_sub = 1'b1;
        state_nxt   = ibb_pkg::S_PADDR;
      end
      ibb_pkg::S_PADDR: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ibb_pkg::S_PRD;
      end
      ibb_pkg::S_PRD: begin
        cmd.rd_go = 1'b1;
        state_nxt = ibb_pkg::S_PACC;
      end
      ibb_pkg::S_PACC: begin
        cmd.acc_add = 1'b1;
        x_nxt       = x_r + SW'(1);
        state_nxt   = ibb_pkg::S_DIV;
      end
      default: state_nxt = ibb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ibb_pkg::S_IDLE;
      frame_w_r  <= (MAX_WIDTH < 256) ? SW'(MAX_WIDTH) : SW'(256);
      frame_h_r  <= (MAX_HEIGHT < 256) ? SW'(MAX_HEIGHT) : SW'(256);
      radius_r   <= ibb_pkg::RAD_W'(1);
      load_pos_r <= '0;
      read_pos_r <= '0;
      ready_r    <= 1'b0;
      last_r     <= 1'b0;
      blank_r    <= 1'b0;
      vert_r     <= 1'b0;
      round_r    <= '0;
      line_r     <= '0;
      j_r        <= '0;
      x_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      frame_w_r  <= frame_w_nxt;
      frame_h_r  <= frame_h_nxt;
      radius_r   <= radius_nxt;
      load_pos_r <= load_pos_nxt;
      read_pos_r <= read_pos_nxt;
      ready_r    <= ready_nxt;
      last_r     <= last_nxt;
      blank_r    <= blank_nxt;
      vert_r     <= vert_nxt;
      round_r    <= round_nxt;
      line_r     <= line_nxt;
      j_r        <= j_nxt;
      x_r        <= x_nxt;
    end
  end

endmodule

>>> rtl/ibb_datapath.sv
// ----------------------------------------------------------------------------
// ibb_datapath
// Datapath: image and pass stores, address multiplier, four lane sums,
// a shared four-lane restoring divider and the result register.
// ----------------------------------------------------------------------------
module ibb_datapath #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ibb_pkg::cmd_t                 cmd,
  output ibb_pkg::stat_t                stat,
  input  logic [AW-1:0]                 pos_addr,
  input  logic [ibb_pkg::SIZE_W-1:0]    mul_major,
  input  logic [ibb_pkg::SIZE_W-1:0]    mul_minor,
  input  logic [ibb_pkg::SIZE_W-1:0]    mul_w,
  input  logic [ibb_pkg::SIZE_W-1:0]    ks,
  input  logic [ibb_pkg::PIX_W-1:0]     pix_in,
  ibb_out_if.source                     out_item
);

  localparam int BW = ibb_pkg::BYTE_W;
  localparam int SMW = ibb_pkg::SUM_W;

  logic [ibb_pkg::PIX_W-1:0] img_mem  [DEPTH];
  logic [ibb_pkg::PIX_W-1:0] pass_mem [DEPTH];

  logic [ibb_pkg::PIX_W-1:0]  img_rdata_r, pass_rdata_r;
  logic                       rd_pass_r;
  logic [ibb_pkg::PROD_W-1:0] prod_r;
  logic [ibb_pkg::SIZE_W-1:0] minor_r;
  logic [SMW-1:0]             sum_r [ibb_pkg::LANES];
  logic [SMW-1:0]             rem_r [ibb_pkg::LANES];
  logic [BW-1:0]              quot_r [ibb_pkg::LANES];
  logic [2:0]                 div_cnt_r;
  logic                       div_busy_r;
  logic [BW-1:0]              out_lane_r [ibb_pkg::LANES];
  logic                       out_last_r, out_nf_r, out_valid_r;

  logic [AW-1:0]             blk_addr;
  logic [ibb_pkg::PIX_W-1:0] rdata;
  logic [ibb_pkg::PIX_W-1:0] quot_word;
  logic                      img_we, img_re, pass_we, pass_re;
  logic [AW-1:0]             img_waddr, img_raddr;
  logic [ibb_pkg::PIX_W-1:0] img_wdata;
  logic [SMW-1:0]            div_step;

  assign blk_addr = AW'((ibb_pkg::PROD_W+1)'(prod_r) + (ibb_pkg::PROD_W+1)'(minor_r));
  assign rdata    = rd_pass_r ? pass_rdata_r : img_rdata_r;
  assign quot_word = {quot_r[3], quot_r[2], quot_r[1], quot_r[0]};
  assign div_step = SMW'(ks) << div_cnt_r;

  // horizontal passes read the image store, vertical passes the pass store
  assign img_we    = cmd.ld_wr || (cmd.wr_go && cmd.src_pass);
  assign img_waddr = cmd.ld_wr ? pos_addr : blk_addr;
  assign img_wdata = cmd.ld_wr ? pix_in : quot_word;
  assign img_re    = cmd.fetch_rd || (cmd.rd_go && !cmd.src_pass);
  assign img_raddr = cmd.fetch_rd ? pos_addr : blk_addr;
  assign pass_we   = cmd.wr_go && !cmd.src_pass;
  assign pass_re   = cmd.rd_go && cmd.src_pass;

  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_waddr] <= img_wdata;
    if (img_re) img_rdata_r <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (pass_we) pass_mem[blk_addr] <= quot_word;
    if (pass_re) pass_rdata_r <= pass_mem[blk_addr];
  end

  always_ff @(posedge clk) begin
    if (img_re || pass_re) rd_pass_r <= pass_re;
    if (cmd.mul_go) begin
      prod_r  <= ibb_pkg::PROD_W'(mul_major) * ibb_pkg::PROD_W'(mul_w);
      minor_r <= mul_minor;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ibb_pkg::LANES; i++) begin
      if (cmd.clr_sums) sum_r[i] <= '0;
      else if (cmd.acc_add) sum_r[i] <= sum_r[i] + SMW'(rdata[i*BW +: BW]);
      else if (cmd.acc_sub) sum_r[i] <= sum_r[i] - SMW'(rdata[i*BW +: BW]);
    end
  end

  // one quotient bit per lane each cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 3'd7;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - 3'd1;
      if (div_cnt_r == 3'd0) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ibb_pkg::LANES; i++) begin
      if (cmd.div_start) begin
        rem_r[i]  <= sum_r[i];
        quot_r[i] <= '0;
      end else if (div_busy_r) begin
        if (rem_r[i] >= div_step) begin
          rem_r[i]  <= rem_r[i] - div_step;
          quot_r[i] <= {quot_r[i][BW-2:0], 1'b1};
        end else begin
          quot_r[i] <= {quot_r[i][BW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < ibb_pkg::LANES; i++) begin
        out_lane_r[i] <= cmd.out_blank ? '0 : img_rdata_r[i*BW +: BW];
      end
      out_last_r <= cmd.out_last;
      out_nf_r   <= cmd.out_blank;
    end
  end

  assign stat.div_busy = div_busy_r;
  assign stat.out_busy = out_valid_r && !out_item.ready;

  assign out_item.valid      = out_valid_r;
  assign out_item.out_lane0  = out_lane_r[0];
  assign out_item.out_lane1  = out_lane_r[1];
  assign out_item.out_lane2  = out_lane_r[2];
  assign out_item.out_lane3  = out_lane_r[3];
  assign out_item.last_pixel = out_last_r;
  assign out_item.no_frame   = out_nf_r;

endmodule

>>> test/iterated_box_blur_rgba_tb.sv
// ----------------------------------------------------------------------------
// iterated_box_blur_rgba_tb
// Self-checking bench for the iterated box blur. Loads frames of random
// pixels under many frame sizes and radii, fetches the blurred readout and
// compares every result against an in-bench model of the three blur rounds,
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module iterated_box_blur_rgba_tb;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned MAX_DIM     = 256;
  localparam int unsigned NUM_ROUNDS  = 3;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam logic [ibb_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] lane3;
    logic [7:0] lane2;
    logic [7:0] lane1;
    logic [7:0] lane0;
    logic       last;
    logic       none;
  } blur_pixel_t;

  logic clk;
  logic rst_n;
  logic                       cfg_we;
  logic [ibb_pkg::CIDX_W-1:0] cfg_index;
  logic [ibb_pkg::SIZE_W-1:0] cfg_data;

  ibb_in_if  in_if();
  ibb_out_if out_if();

  iterated_box_blur_rgba dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Model state
  logic [31:0] img_mem  [0:STORE_DEPTH-1];
  logic [31:0] pass_mem [0:STORE_DEPTH-1];
  int unsigned frame_w, frame_h, radius;
  int unsigned load_pos, fetch_pos;
  bit          frame_rdy;

  blur_pixel_t blurred_q[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_cycles;
  bit          quiet;
  int unsigned out_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result receiver: random stalls, or a long hold when requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  function automatic logic [31:0] store_read(bit from_img, int unsigned idx);
    return from_img ? img_mem[idx] : pass_mem[idx];
  endfunction

  function automatic void box_filter_line(bit from_img, int unsigned base,
                                          int unsigned stride, int unsigned len,
                                          int unsigned r);
    int unsigned sums[4];
    int unsigned ks, cx, x, ox, ix;
    int k;
    logic [31:0] px, po, pi, o;
    ks = 2 * r + 1;
    sums = '{0, 0, 0, 0};
    for (k = -int'(r); k <= int'(r); k++) begin
      cx = (k < 0) ? 0 : ((k >= int'(len)) ? len - 1 : k);
      px = store_read(from_img, base + cx * stride);
      for (int c = 0; c < 4; c++) sums[c] += px[8*c +: 8];
    end
    for (x = 0; x < len; x++) begin
      ox = (x < r) ? 0 : x - r;
      ix = (x + r + 1 >= len) ? len - 1 : x + r + 1;
      po = store_read(from_img, base + ox * stride);
      pi = store_read(from_img, base + ix * stride);
      for (int c = 0; c < 4; c++) o[8*c +: 8] = 8'(sums[c] / ks);
      if (from_img) pass_mem[base + x * stride] = o;
      else img_mem[base + x * stride] = o;
      for (int c = 0; c < 4; c++) sums[c] = sums[c] + pi[8*c +: 8] - po[8*c +: 8];
    end
  endfunction

  function automatic void blur_frame_model();
    for (int unsigned n = 0; n < NUM_ROUNDS; n++) begin
      for (int unsigned i = 0; i < frame_h; i++)
        box_filter_line(1'b1, i * frame_w, 1, frame_w, radius);
      for (int unsigned i = 0; i < frame_w; i++)
        box_filter_line(1'b0, i, frame_w, frame_h, radius);
    end
  endfunction

  function automatic void predict_item(logic m, logic [31:0] px);
    int unsigned total;
    blur_pixel_t res;
    logic [31:0] v;
    total = frame_w * frame_h;
    if (m == ibb_pkg::MODE_LOAD) begin
      frame_rdy = 1'b0;
      img_mem[load_pos % STORE_DEPTH] = px;
      load_pos++;
      if (load_pos >= total) begin
        blur_frame_model();
        load_pos  = 0;
        fetch_pos = 0;
        frame_rdy = 1'b1;
      end
    end else if (!frame_rdy) begin
      res = '0;
      res.none = 1'b1;
      blurred_q.push_back(res);
    end else begin
      v = img_mem[fetch_pos % STORE_DEPTH];
      res = {v[31:24], v[23:16], v[15:8], v[7:0], 1'b0, 1'b0};
      res.last = (fetch_pos + 1 >= total);
      blurred_q.push_back(res);
      if (res.last) begin
        frame_rdy = 1'b0;
        fetch_pos = 0;
      end else begin
        fetch_pos++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    blur_pixel_t exp_px;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (blurred_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h %0h %0h %0h",
                 $time, out_if.out_lane0, out_if.out_lane1, out_if.out_lane2,
                 out_if.out_lane3);
        n_errors++;
      end else begin
        exp_px = blurred_q.pop_front();
        check_field("out_lane0", exp_px.lane0, out_if.out_lane0);
        check_field("out_lane1", exp_px.lane1, out_if.out_lane1);
        check_field("out_lane2", exp_px.lane2, out_if.out_lane2);
        check_field("out_lane3", exp_px.lane3, out_if.out_lane3);
        check_field("last_pixel", 8'(exp_px.last), 8'(out_if.last_pixel));
        check_field("no_frame", 8'(exp_px.none), 8'(out_if.no_frame));
      end
    end
  end

  task automatic send_item(logic m, logic [31:0] px);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.lane0 <= px[7:0];
    in_if.lane1 <= px[15:8];
    in_if.lane2 <= px[23:16];
    in_if.lane3 <= px[31:24];
    do @(posedge clk); while (!in_if.ready);
    predict_item(m, px);
    n_sent++;
  endtask

  task automatic send_load(logic [31:0] px);
    send_item(ibb_pkg::MODE_LOAD, px);
  endtask

  task automatic send_fetch();
    send_item(ibb_pkg::MODE_FETCH, $urandom());
  endtask

  // Drop valid, let all results arrive, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(logic [ibb_pkg::CIDX_W-1:0] idx,
                           logic [ibb_pkg::SIZE_W-1:0] data);
    int unsigned v;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    v = data;
    case (idx)
      ibb_pkg::CFG_FRAME_WIDTH:  frame_w = (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
      ibb_pkg::CFG_FRAME_HEIGHT: frame_h = (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
      ibb_pkg::CFG_BLUR_RADIUS: begin
        v = data[7:0];
        radius = (v < 1) ? 1 : ((v > ibb_pkg::RADIUS_MAX) ? ibb_pkg::RADIUS_MAX : v);
      end
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    drain();
    cfg_write(ibb_pkg::CFG_FRAME_WIDTH, ibb_pkg::SIZE_W'(w));
    cfg_write(ibb_pkg::CFG_FRAME_HEIGHT, ibb_pkg::SIZE_W'(h));
    cfg_write(ibb_pkg::CFG_BLUR_RADIUS, ibb_pkg::SIZE_W'(r));
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    px = $urandom();
    if ($urandom_range(9) == 0)
      for (int c = 0; c < 4; c++) px[8*c +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    return px;
  endfunction

  task automatic load_frame(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_load(rand_pixel());
  endtask

  task automatic fetch_n(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_fetch();
  endtask

  task automatic test_no_frame();
    fetch_n(2);
  endtask

  task automatic test_extremes();
    set_frame(0, 0, 0);
    send_load(32'h0000_0000);
    fetch_n(2);
    send_load(32'hFFFF_FFFF);
    fetch_n(2);
    set_frame(3, 2, 255);
    cfg_write(CFG_UNUSED, 9'h1FF);
    send_load(32'hFFFF_FFFF);
    send_load(32'h0000_0000);
    load_frame(4);
    fetch_n(7);
    set_frame(511, 1, 1);
    load_frame(256);
    fetch_n(257);
    set_frame(1, 511, 2);
    load_frame(256);
    fetch_n(257);
  endtask

  task automatic test_load_during_readout();
    set_frame(2, 2, 1);
    load_frame(4);
    fetch_n(2);
    send_load(rand_pixel());
    send_fetch();
    load_frame(3);
    fetch_n(5);
  endtask

  task automatic test_resize_while_loading();
    set_frame(3, 3, 1);
    load_frame(4);
    drain();
    cfg_write(ibb_pkg::CFG_FRAME_WIDTH, 9'd2);
    load_frame(2);
    fetch_n(7);
  endtask

  task automatic test_resize_during_readout();
    set_frame(4, 4, 2);
    load_frame(16);
    fetch_n(3);
    drain();
    // shrink only, so the readout stays inside loaded pixels
    cfg_write(ibb_pkg::CFG_FRAME_HEIGHT, 9'd2);
    fetch_n(6);
  endtask

  task automatic test_backpressure();
    set_frame(3, 3, 1);
    quiet = 1'b1;
    load_frame(9);
    @(negedge clk);
    out_hold = 300;
    fetch_n(30);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int unsigned start, w, h, r, n;
    start = n_sent;
    while (n_sent - start < RANDOM_ITEMS) begin
      // finish any pending readout before resizing
      while (frame_rdy) send_fetch();
      quiet = ($urandom_range(7) == 0);
      w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(19))
        0:       r = 0;
        1:       r = $urandom_range(4, 12);
        2: begin
          r = $urandom_range(200, 255);
          w = $urandom_range(1, 4);
          h = $urandom_range(1, 4);
        end
        default: r = $urandom_range(1, 3);
      endcase
      set_frame(w, h, r);
      n = frame_w * frame_h;
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(24) == 0) send_fetch();
        send_load(rand_pixel());
      end
      n = n + $urandom_range(1);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(32) == 0) send_load(rand_pixel());
        send_fetch();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_cycles = 0;
    quiet = 1'b0;
    out_hold = 0;
    frame_w = MAX_DIM;
    frame_h = MAX_DIM;
    radius = 1;
    load_pos = 0;
    fetch_pos = 0;
    frame_rdy = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mode = ibb_pkg::MODE_LOAD;
    in_if.lane0 = '0;
    in_if.lane1 = '0;
    in_if.lane2 = '0;
    in_if.lane3 = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_no_frame();
    test_extremes();
    test_load_during_readout();
    test_resize_while_loading();
    test_resize_during_readout();
    test_backpressure();
    test_random();

    drain();
    repeat (50) @(negedge clk);
    if (n_errors == 0 && blurred_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
